// ----- sv/sbc_media_payload_deframer_top_defines.svh -----
// Assertion macros for the deframer's checker file.
`ifndef SBC_MEDIA_PAYLOAD_DEFRAMER_TOP_DEFINES_SVH
`define SBC_MEDIA_PAYLOAD_DEFRAMER_TOP_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define SMPD_ASSERT_CLK(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error(msg);

// Concurrent assertion on the block's own clk_i and rst_ni.
`define SMPD_ASSERT(name, prop, msg) \
  `SMPD_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`endif

// ----- sv/smpd_pkg.sv -----
// Types and constants shared by the media payload deframer modules.
`default_nettype none

package smpd_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CfgPlayerOpen  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgChannelMode = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgChannels    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSubbands    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgBlocks      = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgBitpool     = 3'd5;

  localparam logic [3:0] ResetChannelMode = 4'd8;
  localparam logic [1:0] ResetChannels    = 2'd2;
  localparam logic [3:0] ResetSubbands    = 4'd8;
  localparam logic [4:0] ResetBlocks      = 5'd16;
  localparam logic [7:0] ResetBitpool     = 8'd53;

  localparam logic [3:0] ModeMono   = 4'h8;
  localparam logic [3:0] ModeDual   = 4'h4;
  localparam logic [3:0] ModeStereo = 4'h2;

  localparam logic [7:0] SyncSbc     = 8'h9C;
  localparam logic [7:0] SyncMsbc    = 8'hAD;
  localparam logic [4:0] MsbcBlocks  = 5'd15;
  localparam logic [7:0] MsbcBitpool = 8'd26;
  localparam logic [3:0] FrameCountMask = 4'hF;

  typedef enum logic [1:0] {
    KindData    = 2'd0,
    KindDrop    = 2'd1,
    KindBadSync = 2'd2,
    KindShort   = 2'd3
  } smpd_kind_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] packet_length;
  } smpd_in_t;

  typedef struct packed {
    smpd_kind_e  kind;
    logic [7:0]  out_byte;
    logic        chunk_last;
  } smpd_out_t;

  // One queue entry: a single result, or the three held frame header bytes.
  typedef struct packed {
    logic        triple;
    smpd_kind_e  kind;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic        last;
  } smpd_op_t;

endpackage

`default_nettype wire

// ----- sv/smpd_stream_if.sv -----
// Valid/ready stream interface carrying one payload item per handshake.
`default_nettype none

interface smpd_stream_if #(
  parameter type T = logic [7:0]
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- sv/sbc_media_payload_deframer_top.sv -----
// Top level of the SBC media payload deframer.
//
// Bytes of one media packet enter on in_i, header byte first, each carrying
// the total packet length. Result items leave on out_o: forwarded payload
// bytes with a chunk_last flag, or one status item when a packet is dropped
// or frame parsing stops. Both channels move an item when valid and ready are
// high at a rising clock edge. The user must write the codec registers on
// the cfg port only while no packet is in flight; the block does not enforce
// this. They are sampled on a packet's header byte. One input item is taken
// per cycle while the queue has room. Results pass through the queue and then
// the output register; the third byte of a frame header releases three
// results in turn, which the queue absorbs. Input ready drops for the cycle
// that follows a register write while the frame length is recomputed. When
// the receiver stalls, the output register holds, the queue fills, and then
// input ready drops. Reset returns the registers to their defaults and the
// parser to waiting for a packet header; no clearing pass is needed.
`default_nettype none

module sbc_media_payload_deframer_top
  import smpd_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  smpd_stream_if.sink              in_i,
  smpd_stream_if.source            out_o
);

  smpd_stream_if #(.T(smpd_op_t)) op_push ();
  smpd_stream_if #(.T(smpd_op_t)) op_pop ();

  smpd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .op_o       (op_push)
  );

  smpd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (op_push),
    .out_o  (op_pop)
  );

  smpd_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op_pop),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

// ----- sv/smpd_queue.sv -----
// Short FIFO between the classifying front end and the result back end.
`default_nettype none

module smpd_queue
  import smpd_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  smpd_stream_if.sink     in_i,
  smpd_stream_if.source   out_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  smpd_op_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign in_i.ready    = (count_q != CntFull);
  assign out_o.valid   = (count_q != '0);
  assign out_o.payload = mem_q[rd_ptr_q];
  assign push          = in_i.valid && in_i.ready;
  assign pop           = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_i.payload;
    end
  end

endmodule

`default_nettype wire

// ----- sv/smpd_front.sv -----
// Front end: codec registers, packet and frame header parsing, result classification.
`default_nettype none

module smpd_front
  import smpd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  smpd_stream_if.sink              in_i,
  smpd_stream_if.source            op_o
);

  typedef enum logic [1:0] {
    RunIdle  = 2'd0,
    RunWhole = 2'd1,
    RunParse = 2'd2,
    RunSkip  = 2'd3
  } run_mode_e;

  logic        player_open_q;
  logic [3:0]  chmode_q;
  logic [1:0]  chans_q;
  logic [3:0]  subbands_q;
  logic [4:0]  blocks_q;
  logic [7:0]  bitpool_q;
  logic        cfg_wr_q;
  logic [11:0] efl_q, efl_d;

  run_mode_e   mode_q, mode_d;
  logic [15:0] rem_q, rem_d;
  logic [10:0] fl_q, fl_d;
  logic [1:0]  seen_q, seen_d;
  logic [7:0]  hold0_q, hold0_d, hold1_q, hold1_d;

  logic [7:0]  in_byte;
  logic [15:0] plen, body_len, expect_len;
  logic        fire, push;
  smpd_op_t    op;

  // Expected frame length from the negotiated codec settings.
  logic [5:0]  e_sc;
  logic [6:0]  e_bc, e_fac;
  logic [14:0] e_prod;
  logic [15:0] e_acc;
  logic        e_mono_dual, e_joint;

  // Frame length from the held frame header.
  logic        p_msbc, p_two;
  logic [1:0]  p_mode;
  logic [4:0]  p_blk;
  logic [3:0]  p_sub;
  logic [7:0]  p_bp;
  logic [12:0] p_prod;
  logic [13:0] p_acc;
  logic [10:0] p_base, flen;
  logic        p_short;

  assign in_byte     = in_i.payload.data_byte;
  assign plen        = in_i.payload.packet_length;
  assign body_len    = plen - 16'd1;
  assign expect_len  = 16'(efl_q) * 16'(in_byte[3:0] & FrameCountMask);

  always_comb begin
    e_mono_dual = (chmode_q == ModeMono) || (chmode_q == ModeDual);
    e_joint     = !e_mono_dual && (chmode_q != ModeStereo);
    e_sc        = 6'(subbands_q) * 6'(chans_q);
    e_bc        = 7'(blocks_q) * 7'(chans_q);
    e_fac       = e_mono_dual ? e_bc : 7'(blocks_q);
    e_prod      = 15'(e_fac) * 15'(bitpool_q);
    e_acc       = 16'(e_prod) + 16'd7 + (e_joint ? 16'(subbands_q) : 16'd0);
    efl_d       = 12'd4 + 12'(e_sc[5:1]) + 12'(e_acc[15:3]);
  end

  always_comb begin
    p_msbc = (hold0_q == SyncMsbc);
    p_mode = p_msbc ? 2'd0 : hold1_q[3:2];
    p_blk  = p_msbc ? MsbcBlocks : ({1'b0, hold1_q[5:4], 2'b00} + 5'd4);
    p_sub  = (p_msbc || hold1_q[0]) ? 4'd8 : 4'd4;
    p_bp   = p_msbc ? MsbcBitpool : in_byte;
    p_two  = (p_mode != 2'd0);
    p_base = 11'd4 + (p_two ? 11'(p_sub) : 11'(p_sub[3:1]));
    p_prod = 13'(p_blk) * 13'(p_bp);
    if (p_mode == 2'd1) begin
      p_acc = {p_prod, 1'b0} + 14'd7;
    end else if (p_mode == 2'd3) begin
      p_acc = 14'(p_prod) + 14'(p_sub) + 14'd7;
    end else begin
      p_acc = 14'(p_prod) + 14'd7;
    end
    flen    = p_base + p_acc[13:3];
    p_short = {6'd0, flen} > ({1'b0, rem_q} + 17'd2);
  end

  assign in_i.ready  = op_o.ready && !cfg_wr_q;
  assign fire        = in_i.valid && in_i.ready;
  assign op_o.valid  = push;
  assign op_o.payload = op;

  always_comb begin
    mode_d  = mode_q;
    rem_d   = rem_q;
    fl_d    = fl_q;
    seen_d  = seen_q;
    hold0_d = hold0_q;
    hold1_d = hold1_q;
    push    = 1'b0;
    op      = '{triple: 1'b0, kind: KindData, byte0: 8'd0, byte1: 8'd0,
                byte2: 8'd0, last: 1'b0};
    if (fire) begin
      unique case (mode_q)
        RunIdle: begin
          if (plen != 16'd0) begin
            rem_d  = body_len;
            seen_d = 2'd0;
            fl_d   = 11'd0;
            if (!player_open_q) begin
              push    = 1'b1;
              op.kind = KindDrop;
              mode_d  = RunSkip;
            end else begin
              mode_d = (body_len == expect_len) ? RunWhole : RunParse;
            end
          end
        end
        RunWhole: begin
          push     = 1'b1;
          op.byte0 = in_byte;
          op.last  = (rem_q == 16'd1);
        end
        RunParse: begin
          if (fl_q != 11'd0) begin
            push     = 1'b1;
            op.byte0 = in_byte;
            op.last  = (fl_q == 11'd1);
            fl_d     = fl_q - 11'd1;
          end else if (seen_q == 2'd0) begin
            if (rem_q < 16'd3) begin
              push    = 1'b1;
              op.kind = KindShort;
              mode_d  = RunSkip;
            end else if (in_byte != SyncSbc && in_byte != SyncMsbc) begin
              push    = 1'b1;
              op.kind = KindBadSync;
              mode_d  = RunSkip;
            end else begin
              hold0_d = in_byte;
              seen_d  = 2'd1;
            end
          end else if (seen_q == 2'd1) begin
            hold1_d = in_byte;
            seen_d  = 2'd2;
          end else begin
            seen_d = 2'd0;
            push   = 1'b1;
            if (p_short) begin
              op.kind = KindShort;
              mode_d  = RunSkip;
            end else begin
              op.triple = 1'b1;
              op.byte0  = hold0_q;
              op.byte1  = hold1_q;
              op.byte2  = in_byte;
              fl_d      = flen - 11'd3;
            end
          end
        end
        RunSkip: begin
        end
        default: begin
        end
      endcase
      if (mode_q != RunIdle) begin
        rem_d = rem_q - 16'd1;
      end
      if (mode_d != RunIdle && rem_d == 16'd0) begin
        mode_d = RunIdle;
        seen_d = 2'd0;
        fl_d   = 11'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      player_open_q <= 1'b0;
      chmode_q      <= ResetChannelMode;
      chans_q       <= ResetChannels;
      subbands_q    <= ResetSubbands;
      blocks_q      <= ResetBlocks;
      bitpool_q     <= ResetBitpool;
      cfg_wr_q      <= 1'b0;
      efl_q         <= '0;
      mode_q        <= RunIdle;
      rem_q         <= '0;
      fl_q          <= '0;
      seen_q        <= '0;
      hold0_q       <= '0;
      hold1_q       <= '0;
    end else begin
      cfg_wr_q <= cfg_we_i;
      efl_q    <= efl_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgPlayerOpen:  player_open_q <= cfg_data_i[0];
          CfgChannelMode: chmode_q      <= cfg_data_i[3:0];
          CfgChannels:    chans_q       <= cfg_data_i[1:0];
          CfgSubbands:    subbands_q    <= cfg_data_i[3:0];
          CfgBlocks:      blocks_q      <= cfg_data_i[4:0];
          CfgBitpool:     bitpool_q     <= cfg_data_i[7:0];
          default: begin
          end
        endcase
      end
      mode_q  <= mode_d;
      rem_q   <= rem_d;
      fl_q    <= fl_d;
      seen_q  <= seen_d;
      hold0_q <= hold0_d;
      hold1_q <= hold1_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/smpd_back.sv -----
// Back end: unpacks queue entries into result items behind an output register.
`default_nettype none

module smpd_back
  import smpd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  smpd_stream_if.sink   op_i,
  smpd_stream_if.source out_o
);

  localparam logic [1:0] PartFirst = 2'd0;
  localparam logic [1:0] PartMid   = 2'd1;
  localparam logic [1:0] PartLast  = 2'd2;

  smpd_op_t   head;
  smpd_out_t  out_q, out_d;
  logic       out_valid_q;
  logic [1:0] idx_q;
  logic       load, entry_done;

  assign head       = op_i.payload;
  assign load       = op_i.valid && (!out_valid_q || out_o.ready);
  assign entry_done = !head.triple || (idx_q == PartLast);
  assign op_i.ready = load && entry_done;

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  always_comb begin
    out_d.kind       = head.kind;
    out_d.chunk_last = head.last && !head.triple;
    case (idx_q)
      PartFirst: out_d.out_byte = head.byte0;
      PartMid:   out_d.out_byte = head.byte1;
      default:   out_d.out_byte = head.byte2;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= PartFirst;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= entry_done ? PartFirst : idx_q + 2'd1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/smpd_checker.sv -----
// Port-level assertions for the deframer top level, with their bind.
`default_nettype none

`include "sbc_media_payload_deframer_top_defines.svh"

module smpd_checker
  import smpd_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      cfg_we_i,
  input wire logic      in_ready_i,
  input wire logic      out_valid_i,
  input wire logic      out_ready_i,
  input wire smpd_out_t out_payload_i
);

  // Input is not ready in the cycle after a register write.
  `SMPD_ASSERT(a_cfg_holds_input, cfg_we_i |=> !in_ready_i, "input taken after a register write")

  // Status items carry no byte and never close a chunk.
  `SMPD_ASSERT(a_status_clean, (out_valid_i && out_payload_i.kind != KindData) |-> (out_payload_i.out_byte == 8'd0 && !out_payload_i.chunk_last), "status item with data")

  `SMPD_ASSERT(a_out_hold, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_payload_i)), "stalled result changed")

endmodule

bind sbc_media_payload_deframer_top smpd_checker u_smpd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_payload_i (out_o.payload)
);

`default_nettype wire
